FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define CHK_ALWAYS(lbl, ck, rst_n, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPLY(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

FILE: sv/olar_pkg.sv
`default_nettype none
package olar_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_TYPE_W = 2;
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 5;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 6;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_RANGE     = 3'd3,
		ST_FULL      = 3'd4
	} status_e;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic run;     // advance the token
		logic remove;  // compare and close the gap
		logic found;   // match seen at an earlier cell
		logic append;  // write the cell at the tail
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/olar_req_if.sv
`default_nettype none
interface olar_req_if;
	logic                              valid;
	logic                              ready;
	logic [olar_pkg::REQ_TYPE_W-1:0]   req_type;
	logic [olar_pkg::VALUE_W-1:0]      value;
	logic [olar_pkg::INDEX_W-1:0]      index;

	modport source (output valid, req_type, value, index, input ready);
	modport sink (input valid, req_type, value, index, output ready);
endinterface
`default_nettype wire

FILE: sv/olar_rsp_if.sv
`default_nettype none
interface olar_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [olar_pkg::VALUE_W-1:0]   read_data;
	olar_pkg::status_e              status;
	logic [olar_pkg::COUNT_W-1:0]   entry_count;
	logic                           is_empty;

	modport source (output valid, read_data, status, entry_count, is_empty, input ready);
	modport sink (input valid, read_data, status, entry_count, is_empty, output ready);
endinterface
`default_nettype wire

FILE: sv/olar_cell.sv
`default_nettype none
module olar_cell #(
	parameter int DATA_WIDTH = olar_pkg::DATA_WIDTH_DEF,
	parameter int CW         = 6,
	parameter int IDX        = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire olar_pkg::cell_ctl_t   ctl,
	input  wire logic [DATA_WIDTH-1:0] wr_value,
	input  wire logic [DATA_WIDTH-1:0] cmp_value,
	input  wire logic [CW-1:0]         cnt,
	input  wire logic                  tok_in,
	input  wire logic [DATA_WIDTH-1:0] data_nxt,
	output logic                       tok,
	output logic [DATA_WIDTH-1:0]      data,
	output logic                       hit,
	output logic [DATA_WIDTH-1:0]      bus
);

	logic                  tok_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  shift;

	assign hit   = ctl.remove & tok_q & (data_q == cmp_value);
	// Once the match is at or behind this cell, pull the neighbor's entry up.
	assign shift = ctl.remove & tok_q & (ctl.found | hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= ctl.run & tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && cnt == CW'(IDX)) begin
			data_q <= wr_value;
		end else if (shift) begin
			data_q <= data_nxt;
		end
	end

	assign tok  = tok_q;
	assign data = data_q;
	assign bus  = tok_q ? data_q : '0;

endmodule
`default_nettype wire

FILE: sv/olar_ctrl.sv
`default_nettype none
module olar_ctrl #(
	parameter int DEPTH      = olar_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = olar_pkg::DATA_WIDTH_DEF,
	parameter int CW         = $clog2(DEPTH + 1),
	parameter int PW         = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	olar_req_if.sink                   req,
	olar_rsp_if.source                 rsp,
	input  wire logic                  any_hit,
	input  wire logic [DATA_WIDTH-1:0] bus,
	output olar_pkg::cell_ctl_t        ctl,
	output logic                       start,
	output logic [DATA_WIDTH-1:0]      wr_value,
	output logic [DATA_WIDTH-1:0]      cmp_value,
	output logic [CW-1:0]              cnt
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_PUSH = 3'b100
	} state_t;

	state_t                            state_q, state_d;
	logic [CW-1:0]                     cnt_q, cnt_d;
	logic [PW-1:0]                     ptr_q, ptr_d;
	logic [PW-1:0]                     idx_q;
	logic                              remove_q, remove_d;
	logic                              found_q, found_d;
	logic [DATA_WIDTH-1:0]             value_q;
	olar_pkg::status_e                 pend_status_q, pend_status_d;
	logic [olar_pkg::VALUE_W-1:0]      pend_data_q, pend_data_d;
	logic                              rsp_valid_q;
	olar_pkg::status_e                 rsp_status_q;
	logic [olar_pkg::VALUE_W-1:0]      rsp_data_q;
	logic [CW-1:0]                     rsp_cnt_q;
	logic                              acc;
	logic                              append;
	logic                              push;
	logic                              full;
	logic                              last;

	assign acc  = req.valid & req.ready;
	assign full = (cnt_q == CW'(DEPTH));
	assign last = (ptr_q == PW'(cnt_q - CW'(1)));
	assign push = (state_q == S_PUSH) & (~rsp_valid_q | rsp.ready);

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		ptr_d         = ptr_q;
		remove_d      = remove_q;
		found_d       = found_q;
		pend_status_d = pend_status_q;
		pend_data_d   = pend_data_q;
		append        = 1'b0;
		start         = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					pend_status_d = olar_pkg::ST_OK;
					pend_data_d   = '0;
					ptr_d         = '0;
					found_d       = 1'b0;
					state_d       = S_PUSH;
					case (olar_pkg::req_e'(req.req_type))
						olar_pkg::REQ_APPEND: begin
							if (full) begin
								pend_status_d = olar_pkg::ST_FULL;
							end else begin
								append = 1'b1;
								cnt_d  = cnt_q + CW'(1);
							end
						end
						olar_pkg::REQ_REMOVE: begin
							if (cnt_q == '0) begin
								pend_status_d = olar_pkg::ST_EMPTY;
							end else begin
								start    = 1'b1;
								remove_d = 1'b1;
								state_d  = S_WALK;
							end
						end
						olar_pkg::REQ_READ: begin
							if (cnt_q == '0) begin
								pend_status_d = olar_pkg::ST_EMPTY;
							end else if (32'(req.index) >= 32'(cnt_q)) begin
								pend_status_d = olar_pkg::ST_RANGE;
							end else begin
								start    = 1'b1;
								remove_d = 1'b0;
								state_d  = S_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				if (remove_q) begin
					found_d = found_q | any_hit;
					if (last) begin
						if (found_d) begin
							cnt_d = cnt_q - CW'(1);
						end else begin
							pend_status_d = olar_pkg::ST_NOT_FOUND;
						end
						state_d = S_PUSH;
					end else begin
						ptr_d = ptr_q + PW'(1);
					end
				end else begin
					if (ptr_q == idx_q) begin
						pend_data_d = olar_pkg::VALUE_W'(bus);
						state_d     = S_PUSH;
					end else begin
						ptr_d = ptr_q + PW'(1);
					end
				end
			end
			S_PUSH: begin
				if (push) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			remove_q    <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			ptr_q    <= ptr_d;
			remove_q <= remove_d;
			found_q  <= found_d;
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_status_q <= pend_status_d;
		pend_data_q   <= pend_data_d;
		if (acc) begin
			value_q <= DATA_WIDTH'(req.value);
			idx_q   <= PW'(req.index);
		end
		if (push) begin
			rsp_status_q <= pend_status_q;
			rsp_data_q   <= pend_data_q;
			rsp_cnt_q    <= cnt_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_data   = rsp_data_q;
	assign rsp.entry_count = olar_pkg::COUNT_W'(rsp_cnt_q);
	assign rsp.is_empty    = (rsp_cnt_q == '0);

	assign ctl.run    = start | (state_q == S_WALK);
	assign ctl.remove = (state_q == S_WALK) & remove_q;
	assign ctl.found  = found_q;
	assign ctl.append = append;
	assign wr_value   = DATA_WIDTH'(req.value);
	assign cmp_value  = value_q;
	assign cnt        = cnt_q;

endmodule
`default_nettype wire

FILE: sv/ordered_list_append_remove_index.sv
// Append, errors detected on entry and the unused code go straight to staging the result once
// the output is free; remove walks the token over every entry, read walks it up to the index.
// One item in flight; the next is taken the cycle after the result is staged,
// so the token walking the cell row sets the worst case between items.
// Reset clears the count, the walk token and the output valid; entries hold no reset.
`default_nettype none
`include "assert_macros.svh"
module ordered_list_append_remove_index #(
	parameter int DEPTH      = olar_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = olar_pkg::DATA_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	olar_req_if.sink   req,
	olar_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);

	olar_pkg::cell_ctl_t   ctl;
	logic                  start;
	logic [DATA_WIDTH-1:0] wr_value;
	logic [DATA_WIDTH-1:0] cmp_value;
	logic [CW-1:0]         cnt;
	logic [DEPTH-1:0]      tok;
	logic [DEPTH-1:0]      hit;
	logic [DATA_WIDTH-1:0] data [DEPTH];
	logic [DATA_WIDTH-1:0] cbus [DEPTH];
	logic [DATA_WIDTH-1:0] bus;

	olar_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW),
		.PW         (PW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.any_hit   (|hit),
		.bus       (bus),
		.ctl       (ctl),
		.start     (start),
		.wr_value  (wr_value),
		.cmp_value (cmp_value),
		.cnt       (cnt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  tok_in;
		logic [DATA_WIDTH-1:0] data_nxt;

		assign tok_in   = (i == 0) ? start : tok[(i == 0) ? 0 : i - 1];
		assign data_nxt = (i == DEPTH - 1) ? data[i] : data[(i == DEPTH - 1) ? i : i + 1];

		olar_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr_value  (wr_value),
			.cmp_value (cmp_value),
			.cnt       (cnt),
			.tok_in    (tok_in),
			.data_nxt  (data_nxt),
			.tok       (tok[i]),
			.data      (data[i]),
			.hit       (hit[i]),
			.bus       (cbus[i])
		);
	end

	// Only the cell holding the token drives a nonzero word.
	always_comb begin
		bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			bus = bus | cbus[i];
		end
	end

	`CHK_ALWAYS(a_tok_onehot, clk, arst_n, $onehot0(tok))
	`CHK_ALWAYS(a_cnt_bound, clk, arst_n, cnt <= CW'(DEPTH))
	`CHK_IMPLY(a_hit_tok, clk, arst_n, |hit, ctl.remove && $onehot(hit))
	`CHK_IMPLY(a_rd_ok, clk, arst_n, rsp.valid && rsp.read_data != '0, rsp.status == olar_pkg::ST_OK)

endmodule
`default_nettype wire
